[src/assert_macros.svh]
// Assertion macros used by the top level for its concurrent checks.
// Defining ASSERT_OFF before this header turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside of reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

[src/avc_pkg.sv]
// Shared widths, codes, types and helper functions of the ATR volatility classifier.
// Used by the channel interfaces and by every module of the block but avc_ram.
package avc_pkg;

    localparam int MAX_PERIOD      = 64;
    localparam int PRICE_WIDTH     = 32;

    localparam int PTR_WIDTH       = $clog2(MAX_PERIOD);
    localparam int PERIOD_WIDTH    = 7;
    localparam int BPS_WIDTH       = 14;
    localparam int SEEN_WIDTH      = $clog2(MAX_PERIOD + 2);
    localparam int SUM_WIDTH       = PRICE_WIDTH + PTR_WIDTH;
    localparam int AVG_WIDTH       = 32;
    localparam int CLASS_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int DIV_CNT_WIDTH   = $clog2(SUM_WIDTH + 1);

    localparam int BPS_SCALE       = 10000;
    localparam int LHS_WIDTH       = SUM_WIDTH + BPS_WIDTH;
    localparam int TP_WIDTH        = BPS_WIDTH + PERIOD_WIDTH;
    localparam int RHS_WIDTH       = TP_WIDTH + PRICE_WIDTH;
    localparam int CMP_WIDTH       = (LHS_WIDTH > RHS_WIDTH) ? LHS_WIDTH : RHS_WIDTH;
    localparam int OFS_WIDTH       = ((PTR_WIDTH > PERIOD_WIDTH) ? PTR_WIDTH : PERIOD_WIDTH) + 1;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ATR_PERIOD = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_THR    = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_THR   = CFG_INDEX_WIDTH'(2);

    // Register values after reset.
    localparam logic [PERIOD_WIDTH-1:0] RESET_PERIOD   = PERIOD_WIDTH'(14);
    localparam logic [BPS_WIDTH-1:0]    RESET_LOW_THR  = BPS_WIDTH'(30);
    localparam logic [BPS_WIDTH-1:0]    RESET_HIGH_THR = BPS_WIDTH'(70);

    // Volatility class codes.
    localparam logic [CLASS_WIDTH-1:0] CLASS_UNKNOWN = CLASS_WIDTH'(0);
    localparam logic [CLASS_WIDTH-1:0] CLASS_LOW     = CLASS_WIDTH'(1);
    localparam logic [CLASS_WIDTH-1:0] CLASS_NORMAL  = CLASS_WIDTH'(2);
    localparam logic [CLASS_WIDTH-1:0] CLASS_HIGH    = CLASS_WIDTH'(3);

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] period;    // already clamped to 1..MAX_PERIOD
        logic [BPS_WIDTH-1:0]    low_thr;
        logic [BPS_WIDTH-1:0]    high_thr;
    } cfg_regs_t;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] tr;
        logic [PRICE_WIDTH-1:0] close;
        logic                   has_tr;     // a previous close existed
        logic                   drop_old;   // window full, oldest range leaves
        logic                   report;     // enough bars for an average
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // A period of zero acts as one, and one above the ring depth as the depth.
    function automatic logic [PERIOD_WIDTH-1:0] eff_period(input logic [PERIOD_WIDTH-1:0] p);
        logic [PERIOD_WIDTH-1:0] r;
        r = p;
        if (p == '0) begin
            r = PERIOD_WIDTH'(1);
        end
        else if (p > MAX_PERIOD) begin
            r = PERIOD_WIDTH'(MAX_PERIOD);
        end
        return r;
    endfunction

    function automatic logic [PRICE_WIDTH-1:0] abs_diff(input logic [PRICE_WIDTH-1:0] a,
                                                        input logic [PRICE_WIDTH-1:0] b);
        logic [PRICE_WIDTH-1:0] r;
        if (a > b) begin
            r = a - b;
        end
        else begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

[src/avc_bar_if.sv]
// Price bar channel: valid/ready handshake carrying high, low and close.
// Depends on avc_pkg for the price width.
interface avc_bar_if import avc_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;

    modport source (output valid, high_price, low_price, close_price, input ready);
    modport sink   (input valid, high_price, low_price, close_price, output ready);

endinterface

[src/avc_result_if.sv]
// Result channel: valid/ready handshake carrying the class and the average range.
// Depends on avc_pkg for the field widths.
interface avc_result_if import avc_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CLASS_WIDTH-1:0] volatility_class;
    logic [AVG_WIDTH-1:0]   average_range;

    modport source (output valid, volatility_class, average_range, input ready);
    modport sink   (input valid, volatility_class, average_range, output ready);

endinterface

[src/avc_cfg_if.sv]
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on avc_pkg for the index and data widths.
interface avc_cfg_if import avc_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] reg_index;
    logic [CFG_DATA_WIDTH-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);

endinterface

[src/atr_volatility_classifier_unit.sv]
// Top level of the ATR volatility classifier: configuration registers,
// front part, bar queue and back part. Depends on avc_pkg, the channel
// interfaces, avc_front, avc_queue, avc_back and assert_macros.svh.

// Each bar item (high, low, close) yields exactly one result item carrying the
// average true range over the last atr_period bars (sum divided by the period,
// truncated, zero until that many earlier bars exist) and a volatility class
// (unknown, low, normal, high) from an exact comparison of sum * 10000 against
// threshold * period * close. The front part takes a bar in the cycle it is
// offered whenever the two-entry queue has room, computes the true range
// against the previous close and pushes it on. With a full window the back part
// takes a bar through queue pop, ring read, sum update, setup, 38 restoring
// divider steps (one quotient bit per cycle across the 38-bit window sum), two
// multiplies, two compares and the result load; a bar before that skips the
// divider, multiplies and compares, and the first bar also skips the ring
// read and sum update. The back part keeps working while a finished result
// waits in the output register, and the queue lets the front keep accepting up
// to two bars meanwhile. Writing any of the three registers clears all bar
// history; write them only while no bar is in flight. The ring of true ranges
// has no clearing pass, since an entry is always written before it is read.
`include "assert_macros.svh"

module atr_volatility_classifier_unit import avc_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    avc_bar_if.sink      bar,
    avc_result_if.source res,
    avc_cfg_if.sink      cfg
);

    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic [BPS_WIDTH-1:0]    low_thr_reg, low_thr_next;
    logic [BPS_WIDTH-1:0]    high_thr_reg, high_thr_next;

    cfg_regs_t    cfg_regs;
    logic         cfg_write;
    logic         clear;

    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    queue_entry_t head;
    q_status_t    q_status;
    logic         result_load;

    // Registers are always writable; any write to a known index wipes history.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign clear     = cfg_write && (cfg.reg_index == REG_ATR_PERIOD ||
                                     cfg.reg_index == REG_LOW_THR ||
                                     cfg.reg_index == REG_HIGH_THR);

    always_comb
    begin
        period_next   = period_reg;
        low_thr_next  = low_thr_reg;
        high_thr_next = high_thr_reg;
        if (cfg_write)
        begin
            case (cfg.reg_index)
                REG_ATR_PERIOD: period_next   = cfg.wdata[PERIOD_WIDTH-1:0];
                REG_LOW_THR:    low_thr_next  = cfg.wdata[BPS_WIDTH-1:0];
                REG_HIGH_THR:   high_thr_next = cfg.wdata[BPS_WIDTH-1:0];
                default:        period_next   = period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= RESET_PERIOD;
            low_thr_reg  <= RESET_LOW_THR;
            high_thr_reg <= RESET_HIGH_THR;
        end
        else
        begin
            period_reg   <= period_next;
            low_thr_reg  <= low_thr_next;
            high_thr_reg <= high_thr_next;
        end
    end

    // Both parts see the period already clamped into the ring's range.
    assign cfg_regs.period   = eff_period(period_reg);
    assign cfg_regs.low_thr  = low_thr_reg;
    assign cfg_regs.high_thr = high_thr_reg;

    avc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bar        (bar),
        .cfg_regs   (cfg_regs),
        .clear      (clear),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    avc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    avc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_regs),
        .clear       (clear),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .result_load (result_load),
        .res         (res)
    );

    // The front must never push into a full queue.
    `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && q_status.full)
    // The back only takes a bar when the queue holds one.
    `ASSERT_ALWAYS(a_pop_needs_entry, clk, rst_n, pop |-> !q_status.empty)
    // A new result never overwrites one that the sink has not taken.
    `ASSERT_ALWAYS(a_load_slot_free, clk, rst_n, result_load |-> (!res.valid || res.ready))

endmodule

[src/avc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module avc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/avc_front.sv]
// Front part: accepts price bars, forms the true range and the window flags.
// Depends on avc_pkg and avc_bar_if; feeds avc_queue.
module avc_front import avc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    avc_bar_if.sink      bar,
    input  cfg_regs_t    cfg_regs,
    input  logic         clear,
    input  q_status_t    q_status,
    output logic         push,
    output queue_entry_t push_entry
);

    logic [PRICE_WIDTH-1:0] prev_close_reg, prev_close_next;
    logic [SEEN_WIDTH-1:0]  bars_seen_reg, bars_seen_next;

    logic [PRICE_WIDTH-1:0] span;
    logic [PRICE_WIDTH-1:0] gap_high;
    logic [PRICE_WIDTH-1:0] gap_low;
    logic [PRICE_WIDTH-1:0] tr;

    assign bar.ready = !q_status.full;
    assign push      = bar.valid && bar.ready;

    always_comb
    begin
        span     = (bar.high_price > bar.low_price) ? (bar.high_price - bar.low_price) : '0;
        gap_high = abs_diff(bar.high_price, prev_close_reg);
        gap_low  = abs_diff(bar.low_price, prev_close_reg);
        tr       = span;
        if (gap_high > tr)
        begin
            tr = gap_high;
        end
        if (gap_low > tr)
        begin
            tr = gap_low;
        end
    end

    always_comb
    begin
        push_entry.tr       = tr;
        push_entry.close    = bar.close_price;
        push_entry.has_tr   = (bars_seen_reg != '0);
        push_entry.drop_old = (bars_seen_reg > cfg_regs.period);
        push_entry.report   = (bars_seen_reg >= cfg_regs.period);
    end

    always_comb
    begin
        prev_close_next = prev_close_reg;
        bars_seen_next  = bars_seen_reg;
        if (clear)
        begin
            prev_close_next = '0;
            bars_seen_next  = '0;
        end
        else if (push)
        begin
            prev_close_next = bar.close_price;
            if (bars_seen_reg != SEEN_WIDTH'(MAX_PERIOD + 1))
            begin
                bars_seen_next = bars_seen_reg + SEEN_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_close_reg <= '0;
            bars_seen_reg  <= '0;
        end
        else
        begin
            prev_close_reg <= prev_close_next;
            bars_seen_reg  <= bars_seen_next;
        end
    end

endmodule

[src/avc_queue.sv]
// Short FIFO of bar entries (true range, close and window flags) between the front and the back part.
// Depends on avc_pkg for the entry and status types.
module avc_queue import avc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head,
    output q_status_t    status
);

    queue_entry_t          slots [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg, count_next;

    assign head         = slots[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_WIDTH'(1);
            end
            if (push && !pop)
            begin
                count_next = count_reg + QCNT_WIDTH'(1);
            end
            else if (pop && !push)
            begin
                count_next = count_reg - QCNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !clear)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[src/avc_back.sv]
// Back part: keeps the true range ring and its sum, divides by the period,
// classifies by cross-multiplication and holds the result register.
// Depends on avc_pkg, avc_result_if and avc_ram.
module avc_back import avc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_regs_t    cfg_regs,
    input  logic         clear,
    input  q_status_t    q_status,
    input  queue_entry_t head,
    output logic         pop,
    output logic         result_load,
    avc_result_if.source res
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_READ     = 9'b000000010,
        ST_UPDATE   = 9'b000000100,
        ST_CHECK    = 9'b000001000,
        ST_DIVIDE   = 9'b000010000,
        ST_MUL_LOW  = 9'b000100000,
        ST_CMP_LOW  = 9'b001000000,
        ST_CMP_HIGH = 9'b010000000,
        ST_OUT      = 9'b100000000
    } back_state_t;

    back_state_t              state_reg, state_next;
    queue_entry_t             entry_reg, entry_next;
    logic [SUM_WIDTH-1:0]     sum_reg, sum_next;
    logic [PTR_WIDTH-1:0]     ptr_reg, ptr_next;
    logic [PERIOD_WIDTH-1:0]  rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_WIDTH-1:0] count_reg, count_next;
    logic [LHS_WIDTH-1:0]     lhs_reg, lhs_next;
    logic [TP_WIDTH-1:0]      tp_reg, tp_next;
    logic [RHS_WIDTH-1:0]     rhs_reg, rhs_next;
    logic                     below_low_reg, below_low_next;
    logic                     below_high_reg, below_high_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CLASS_WIDTH-1:0]   class_reg, class_next;
    logic [AVG_WIDTH-1:0]     avg_reg, avg_next;

    logic [OFS_WIDTH-1:0]     ptr_ext;
    logic [OFS_WIDTH-1:0]     period_ext;
    logic [OFS_WIDTH-1:0]     old_ofs;
    logic [PTR_WIDTH-1:0]     old_addr;
    logic [PRICE_WIDTH-1:0]   old_range;
    logic                     ram_we;
    logic [PERIOD_WIDTH:0]    shifted;
    logic                     rhs_above;
    logic [RHS_WIDTH-1:0]     product;

    // Oldest stored range of the window sits period entries behind the write pointer.
    always_comb
    begin
        ptr_ext    = OFS_WIDTH'(ptr_reg);
        period_ext = OFS_WIDTH'(cfg_regs.period);
        if (ptr_ext >= period_ext)
        begin
            old_ofs = ptr_ext - period_ext;
        end
        else
        begin
            old_ofs = ptr_ext + OFS_WIDTH'(MAX_PERIOD) - period_ext;
        end
        old_addr = PTR_WIDTH'(old_ofs);
    end

    avc_ram #(
        .WIDTH (PRICE_WIDTH),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (entry_reg.tr),
        .raddr (old_addr),
        .rdata (old_range)
    );

    assign shifted   = {rem_reg, quot_reg[SUM_WIDTH-1]};
    assign product   = RHS_WIDTH'(tp_reg) * RHS_WIDTH'(entry_reg.close);
    assign rhs_above = CMP_WIDTH'(lhs_reg) < CMP_WIDTH'(rhs_reg);

    assign res.valid            = out_valid_reg;
    assign res.volatility_class = class_reg;
    assign res.average_range    = avg_reg;

    always_comb
    begin
        state_next      = state_reg;
        entry_next      = entry_reg;
        sum_next        = sum_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        count_next      = count_reg;
        lhs_next        = lhs_reg;
        tp_next         = tp_reg;
        rhs_next        = rhs_reg;
        below_low_next  = below_low_reg;
        below_high_next = below_high_reg;
        class_next      = class_reg;
        avg_next        = avg_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        result_load     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    entry_next = head;
                    state_next = head.has_tr ? ST_READ : ST_CHECK;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ram_we   = 1'b1;
                sum_next = sum_reg + SUM_WIDTH'(entry_reg.tr)
                           - (entry_reg.drop_old ? SUM_WIDTH'(old_range) : '0);
                ptr_next = (ptr_reg == PTR_WIDTH'(MAX_PERIOD - 1)) ?
                           '0 : ptr_reg + PTR_WIDTH'(1);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (entry_reg.report)
                begin
                    rem_next   = '0;
                    quot_next  = sum_reg;
                    count_next = DIV_CNT_WIDTH'(SUM_WIDTH);
                    lhs_next   = LHS_WIDTH'(sum_reg) * LHS_WIDTH'(BPS_SCALE);
                    tp_next    = TP_WIDTH'(cfg_regs.low_thr) * TP_WIDTH'(cfg_regs.period);
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVIDE:
            begin
                if (shifted >= (PERIOD_WIDTH + 1)'(cfg_regs.period))
                begin
                    rem_next  = PERIOD_WIDTH'(shifted - (PERIOD_WIDTH + 1)'(cfg_regs.period));
                    quot_next = {quot_reg[SUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = PERIOD_WIDTH'(shifted);
                    quot_next = {quot_reg[SUM_WIDTH-2:0], 1'b0};
                end
                count_next = count_reg - DIV_CNT_WIDTH'(1);
                if (count_reg == DIV_CNT_WIDTH'(1))
                begin
                    state_next = ST_MUL_LOW;
                end
            end
            ST_MUL_LOW:
            begin
                rhs_next   = product;
                tp_next    = TP_WIDTH'(cfg_regs.high_thr) * TP_WIDTH'(cfg_regs.period);
                state_next = ST_CMP_LOW;
            end
            ST_CMP_LOW:
            begin
                below_low_next = rhs_above;
                rhs_next       = product;
                state_next     = ST_CMP_HIGH;
            end
            ST_CMP_HIGH:
            begin
                below_high_next = rhs_above;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    result_load = 1'b1;
                    if (!entry_reg.report)
                    begin
                        class_next = CLASS_UNKNOWN;
                        avg_next   = '0;
                    end
                    else
                    begin
                        avg_next = AVG_WIDTH'(quot_reg);
                        if (sum_reg == '0 || entry_reg.close == '0)
                        begin
                            class_next = CLASS_UNKNOWN;
                        end
                        else if (below_low_reg)
                        begin
                            class_next = CLASS_LOW;
                        end
                        else if (below_high_reg)
                        begin
                            class_next = CLASS_NORMAL;
                        end
                        else
                        begin
                            class_next = CLASS_HIGH;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear)
        begin
            sum_next = '0;
            ptr_next = '0;
        end

        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        lhs_reg        <= lhs_next;
        tp_reg         <= tp_next;
        rhs_reg        <= rhs_next;
        below_low_reg  <= below_low_next;
        below_high_reg <= below_high_next;
        class_reg      <= class_next;
        avg_reg        <= avg_next;
    end

endmodule

[test/tb_atr_volatility_classifier_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for atr_volatility_classifier_unit: price bars in, one reading out per bar.
// Depends on avc_pkg, the bar, result and configuration channel interfaces, and the unit itself.
module tb_atr_volatility_classifier_unit;
    import avc_pkg::*;

    // Index past the three registers; a write there must change nothing.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(3);

    localparam logic [PRICE_WIDTH-1:0] PX_MAX = {PRICE_WIDTH{1'b1}};
    localparam int RANDOM_BARS = 1850;
    // The limit covers the slowest legal run of near 2000 bars, each with a full busy
    // computation plus the longest result stall and the longest sender gap.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] hi_px;
        logic [PRICE_WIDTH-1:0] lo_px;
        logic [PRICE_WIDTH-1:0] close_px;
    } price_bar_t;

    typedef struct packed {
        logic [CLASS_WIDTH-1:0] cls;
        logic [AVG_WIDTH-1:0]   avg;
    } reading_t;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_DATA_WIDTH-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side copies of every block input, known from time zero.
    logic                       bar_valid = 1'b0;
    logic [PRICE_WIDTH-1:0]     bar_hi = '0;
    logic [PRICE_WIDTH-1:0]     bar_lo = '0;
    logic [PRICE_WIDTH-1:0]     bar_cl = '0;
    logic                       res_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    avc_bar_if    bar_ch ();
    avc_result_if res_ch ();
    avc_cfg_if    cfg_ch ();

    assign bar_ch.valid       = bar_valid;
    assign bar_ch.high_price  = bar_hi;
    assign bar_ch.low_price   = bar_lo;
    assign bar_ch.close_price = bar_cl;
    assign res_ch.ready       = res_ready;
    assign cfg_ch.valid       = cfg_valid;
    assign cfg_ch.reg_index   = cfg_index;
    assign cfg_ch.wdata       = cfg_data;

    atr_volatility_classifier_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bar   (bar_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pending stimulus, expected readings and bookkeeping.
    price_bar_t bar_backlog[$];
    reg_write_t write_backlog[$];
    reading_t   awaited_readings[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       bar_took = 1'b0;
    logic       cfg_took = 1'b0;

    // Shadow registers and bar history of the predictor.
    logic [PERIOD_WIDTH-1:0] shadow_period = RESET_PERIOD;
    logic [BPS_WIDTH-1:0]    shadow_low_thr = RESET_LOW_THR;
    logic [BPS_WIDTH-1:0]    shadow_high_thr = RESET_HIGH_THR;
    logic [PRICE_WIDTH-1:0]  last_close = '0;
    logic [PRICE_WIDTH-1:0]  ranges [MAX_PERIOD];
    logic [SUM_WIDTH-1:0]    window_sum = '0;
    int unsigned             slot = 0;
    int unsigned             bars_counted = 0;

    task automatic report_mismatch(input string what, input logic [AVG_WIDTH-1:0] got,
                                   input logic [AVG_WIDTH-1:0] want);
        // Every mismatch counts; printing stops after a while to keep the log short.
        if (mismatch_count < 50)
        begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // A register write takes effect at once and wipes the bar history. The ring
    // itself is left alone, since an entry is always rewritten before it is read.
    task automatic apply_reg_write(input reg_write_t w);
        case (w.index)
            REG_ATR_PERIOD: shadow_period = w.data[PERIOD_WIDTH-1:0];
            REG_LOW_THR:    shadow_low_thr = w.data[BPS_WIDTH-1:0];
            REG_HIGH_THR:   shadow_high_thr = w.data[BPS_WIDTH-1:0];
            default:        return;
        endcase
        last_close = '0;
        window_sum = '0;
        slot = 0;
        bars_counted = 0;
    endtask

    // Folds one bar into the window and works out the reading it must produce.
    task automatic advance_window(input price_bar_t b, output reading_t r);
        int unsigned            span;
        int unsigned            oldest;
        logic [PRICE_WIDTH-1:0] tr;
        logic [PRICE_WIDTH-1:0] gap_hi;
        logic [PRICE_WIDTH-1:0] gap_lo;
        logic [127:0]           scaled_sum;
        logic [127:0]           low_bound;
        logic [127:0]           high_bound;

        if (shadow_period == '0)
        begin
            span = 1;
        end
        else if (shadow_period > MAX_PERIOD)
        begin
            span = MAX_PERIOD;
        end
        else
        begin
            span = shadow_period;
        end
        r.cls = CLASS_UNKNOWN;
        r.avg = '0;

        // The first bar of a history has no previous close and yields no range.
        if (bars_counted >= 1)
        begin
            tr = (b.hi_px > b.lo_px) ? b.hi_px - b.lo_px : '0;
            gap_hi = (b.hi_px > last_close) ? b.hi_px - last_close : last_close - b.hi_px;
            gap_lo = (b.lo_px > last_close) ? b.lo_px - last_close : last_close - b.lo_px;
            if (gap_hi > tr) tr = gap_hi;
            if (gap_lo > tr) tr = gap_lo;
            if (bars_counted > span)
            begin
                oldest = (slot + MAX_PERIOD - span) % MAX_PERIOD;
                window_sum = window_sum - ranges[oldest];
            end
            ranges[slot] = tr;
            window_sum = window_sum + tr;
            slot = (slot + 1) % MAX_PERIOD;
        end

        // Ready once a full period of earlier bars exists; the class additionally
        // needs a nonzero sum and a nonzero close, compared exactly in wide math.
        if (bars_counted >= span)
        begin
            r.avg = AVG_WIDTH'(window_sum / span);
            if (window_sum != '0 && b.close_px != '0)
            begin
                scaled_sum = 128'(window_sum) * 128'(BPS_SCALE);
                low_bound  = 128'(shadow_low_thr) * 128'(span) * 128'(b.close_px);
                high_bound = 128'(shadow_high_thr) * 128'(span) * 128'(b.close_px);
                if (scaled_sum < low_bound)
                begin
                    r.cls = CLASS_LOW;
                end
                else if (scaled_sum < high_bound)
                begin
                    r.cls = CLASS_NORMAL;
                end
                else
                begin
                    r.cls = CLASS_HIGH;
                end
            end
        end

        last_close = b.close_px;
        if (bars_counted < MAX_PERIOD + 1) bars_counted++;
    endtask

    // Rising edge: record handshakes, update the predictor and check readings.
    always @(posedge clk)
    begin : watch
        reg_write_t w;
        price_bar_t b;
        reading_t   made;
        reading_t   due;

        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            bar_took <= 1'b0;
            cfg_took <= 1'b0;
        end
        else
        begin
            bar_took <= bar_ch.valid && bar_ch.ready;
            cfg_took <= cfg_ch.valid && cfg_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                w.index = cfg_ch.reg_index;
                w.data  = cfg_ch.wdata;
                apply_reg_write(w);
            end
            if (bar_ch.valid && bar_ch.ready)
            begin
                b.hi_px    = bar_ch.high_price;
                b.lo_px    = bar_ch.low_price;
                b.close_px = bar_ch.close_price;
                advance_window(b, made);
                awaited_readings = {awaited_readings, made};
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_readings.size() == 0)
                begin
                    report_mismatch("unexpected reading, average", res_ch.average_range, '0);
                end
                else
                begin
                    due = awaited_readings.pop_front();
                    if (res_ch.volatility_class !== due.cls)
                    begin
                        report_mismatch("volatility class", AVG_WIDTH'(res_ch.volatility_class),
                                        AVG_WIDTH'(due.cls));
                    end
                    if (res_ch.average_range !== due.avg)
                    begin
                        report_mismatch("average range", res_ch.average_range, due.avg);
                    end
                end
            end
        end
    end

    // Bar sender: bursts of random length separated by random gaps. An item that
    // has not been taken yet is held steady until the block accepts it.
    int burst_left = 0;
    int idle_left = 0;

    always @(negedge clk)
    begin : bar_sender
        price_bar_t nxt;
        int         pick;

        if (!rst_n)
        begin
            bar_valid <= 1'b0;
        end
        else if (!(bar_valid && !bar_took))
        begin
            if (idle_left > 0)
            begin
                bar_valid <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (bar_backlog.size() != 0)
            begin
                nxt = bar_backlog.pop_front();
                bar_hi <= nxt.hi_px;
                bar_lo <= nxt.lo_px;
                bar_cl <= nxt.close_px;
                bar_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    pick = $urandom_range(0, 9);
                    // Mostly no gap or a short one; now and then a gap as long as
                    // the block's whole per-bar computation.
                    if (pick < 4)
                    begin
                        idle_left <= 0;
                    end
                    else if (pick < 8)
                    begin
                        idle_left <= $urandom_range(1, 6);
                    end
                    else
                    begin
                        idle_left <= $urandom_range(10, 50);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                bar_valid <= 1'b0;
            end
        end
    end

    // Reading receiver: runs of ready and of stall, each of random length, from
    // long open stretches to stalls longer than the block's busy time.
    int ready_run = 0;

    always @(negedge clk)
    begin : reading_receiver
        int style;

        if (!rst_n)
        begin
            res_ready <= 1'b0;
            ready_run <= 0;
        end
        else if (ready_run == 0)
        begin
            style = $urandom_range(0, 3);
            case (style)
                0:
                begin
                    res_ready <= 1'b1;
                    ready_run <= $urandom_range(20, 200);
                end
                1:
                begin
                    res_ready <= 1'b0;
                    ready_run <= $urandom_range(1, 4);
                end
                2:
                begin
                    res_ready <= 1'b0;
                    ready_run <= $urandom_range(20, 80);
                end
                default:
                begin
                    res_ready <= 1'b1;
                    ready_run <= $urandom_range(1, 4);
                end
            endcase
        end
        else
        begin
            ready_run <= ready_run - 1;
        end
    end

    // Register writer: one write per accepted handshake, no gaps needed.
    always @(negedge clk)
    begin : reg_writer
        reg_write_t w;

        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else if (!(cfg_valid && !cfg_took))
        begin
            if (write_backlog.size() != 0)
            begin
                w = write_backlog.pop_front();
                cfg_index <= w.index;
                cfg_data  <= w.data;
                cfg_valid <= 1'b1;
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    task automatic queue_bar(input logic [PRICE_WIDTH-1:0] hi_px,
                             input logic [PRICE_WIDTH-1:0] lo_px,
                             input logic [PRICE_WIDTH-1:0] close_px);
        price_bar_t b;
        b.hi_px    = hi_px;
        b.lo_px    = lo_px;
        b.close_px = close_px;
        bar_backlog = {bar_backlog, b};
    endtask

    task automatic queue_write(input logic [CFG_INDEX_WIDTH-1:0] index,
                               input logic [CFG_DATA_WIDTH-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        write_backlog = {write_backlog, w};
    endtask

    // Blocks until nothing is queued, offered or outstanding. Every bar yields a
    // reading, so the block is idle once the last reading has been taken.
    task automatic wait_idle();
        while (bar_backlog.size() != 0 || write_backlog.size() != 0 || bar_valid ||
               cfg_valid || awaited_readings.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Noise: bars that no market would print, covering every price bit.
    task automatic queue_odd_bar();
        logic [PRICE_WIDTH-1:0] a;
        logic [PRICE_WIDTH-1:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 5))
            0: queue_bar(a, b, $urandom);
            1: queue_bar((a < b) ? a : b, (a < b) ? b : a, $urandom);   // high below low
            2: queue_bar(a, b, '0);                                      // zero close
            3: queue_bar(a, a, a);                                       // flat bar
            4: if (a[0]) queue_bar(PX_MAX, PX_MAX, PX_MAX); else queue_bar('0, '0, '0);
            default: queue_bar(PX_MAX, '0, $urandom);
        endcase
    endtask

    // Mostly well-formed bars of a random walk whose ranges scatter around the
    // given volatility in basis points, with occasional opening gaps.
    task automatic queue_market_bars(input int count, input int vol_bps, input longint start_px);
        longint px;
        longint reach;
        longint hi;
        longint lo;
        longint cl;
        int     i;

        px = start_px;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                queue_odd_bar();
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    reach = px * vol_bps * 3 / 10000;
                    if ($urandom_range(0, 1) == 1) px = px + reach;
                    else px = px - reach;
                    if (px < 1) px = 1;
                    if (px > longint'(PX_MAX)) px = longint'(PX_MAX);
                end
                reach = px * $urandom_range(0, 2 * vol_bps) / 10000;
                if (reach > longint'(PX_MAX)) reach = longint'(PX_MAX);
                hi = px + longint'($urandom_range(0, reach));
                lo = px - longint'($urandom_range(0, reach));
                if (hi > longint'(PX_MAX)) hi = longint'(PX_MAX);
                if (lo < 0) lo = 0;
                cl = lo + longint'($urandom_range(0, hi - lo));
                queue_bar(PRICE_WIDTH'(hi), PRICE_WIDTH'(lo), PRICE_WIDTH'(cl));
                px = (cl == 0) ? 1 : cl;
            end
        end
    endtask

    // Register settings for one random phase. The first few phases walk through
    // the extremes; later ones are drawn at random. Unused upper data bits are
    // filled with noise since the block must ignore them.
    task automatic queue_phase_setup(input int phase, output int vol_bps);
        int unsigned per;
        int unsigned low_t;
        int unsigned high_t;
        int unsigned pick;

        case (phase)
            0: begin per = 1;   low_t = 0;     high_t = 10000; end
            1: begin per = 64;  low_t = 30;    high_t = 70;    end
            2: begin per = 127; low_t = 16383; high_t = 16383; end
            3: begin per = 0;   low_t = 120;   high_t = 20;    end
            4: begin per = 2;   low_t = 10000; high_t = 16383; end
            5: begin per = $urandom_range(65, 127); low_t = 0; high_t = 0; end
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0) per = 0;
                else if (pick == 1) per = 1;
                else if (pick == 2) per = 64;
                else if (pick == 3) per = $urandom_range(65, 127);
                else per = $urandom_range(2, 20);
                if ($urandom_range(0, 4) == 0)
                begin
                    low_t  = $urandom_range(0, 16383);
                    high_t = $urandom_range(0, 16383);
                end
                else
                begin
                    low_t  = $urandom_range(0, 120);
                    high_t = low_t + $urandom_range(0, 120);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        pick   = low_t;
                        low_t  = high_t;
                        high_t = pick;
                    end
                end
            end
        endcase

        queue_write(REG_ATR_PERIOD,
                    CFG_DATA_WIDTH'(per) | (CFG_DATA_WIDTH'($urandom) << PERIOD_WIDTH));
        if (phase < 6 || $urandom_range(0, 9) < 7)
        begin
            queue_write(REG_LOW_THR,
                        CFG_DATA_WIDTH'(low_t) | (CFG_DATA_WIDTH'($urandom) << BPS_WIDTH));
        end
        if (phase < 6 || $urandom_range(0, 9) < 7)
        begin
            queue_write(REG_HIGH_THR,
                        CFG_DATA_WIDTH'(high_t) | (CFG_DATA_WIDTH'($urandom) << BPS_WIDTH));
        end
        if ($urandom_range(0, 4) == 0) queue_write(REG_UNUSED, CFG_DATA_WIDTH'($urandom));

        if ($urandom_range(0, 4) == 0) vol_bps = $urandom_range(150, 5000);
        else vol_bps = $urandom_range(0, 150);
    endtask

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int     phase;
        int     planned;
        int     count;
        int     vol_bps;
        longint start_px;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings (period 14): a first bar with no previous
        // close, then extreme bars while the window is not yet ready, one with
        // high below low.
        queue_bar('0, '0, '0);
        queue_bar(PX_MAX, PX_MAX, PX_MAX);
        queue_bar('0, PX_MAX, PX_MAX);
        wait_idle();

        // Period zero acts as one: ready from the second bar. Covers zero close,
        // zero sum, and a low and a high class at the default thresholds.
        queue_write(REG_ATR_PERIOD, '0);
        wait_idle();
        queue_bar(100, 90, 95);
        queue_bar(100, 90, 0);
        queue_bar(50, 50, 50);
        queue_bar(50, 50, 50);
        queue_bar(1000001, 999999, 1000000);
        queue_bar(1003000, 1000000, 1001000);
        wait_idle();

        // A write past the last register must keep the history: the next range
        // still uses the previous close.
        queue_write(REG_UNUSED, CFG_DATA_WIDTH'($urandom));
        wait_idle();
        queue_bar(PX_MAX, '0, PX_MAX);
        wait_idle();

        // Thresholds out of order and above the basis-point scale.
        queue_write(REG_ATR_PERIOD, CFG_DATA_WIDTH'(2));
        queue_write(REG_LOW_THR, CFG_DATA_WIDTH'(16383));
        queue_write(REG_HIGH_THR, '0);
        wait_idle();
        queue_bar(10, 5, 8);
        queue_bar(12, 6, 9);
        queue_bar(20, 1, 10);
        wait_idle();

        queue_write(REG_LOW_THR, '0);
        queue_write(REG_HIGH_THR, CFG_DATA_WIDTH'(10000));
        wait_idle();
        queue_bar(10, 5, 8);
        queue_bar(12, 6, 9);
        queue_bar(20, 1, 10);
        queue_bar(1000, 0, 1);
        wait_idle();

        // Random part: phases of market-like bars with noise, each under fresh
        // register settings written while the block is idle.
        planned = 0;
        phase = 0;
        while (planned < RANDOM_BARS)
        begin
            queue_phase_setup(phase, vol_bps);
            wait_idle();
            case ($urandom_range(0, 2))
                0:       start_px = $urandom_range(50, 5000);
                1:       start_px = $urandom_range(100000, 50000000);
                default: start_px = $urandom_range(1000000000, 32'hFFFF_0000);
            endcase
            count = $urandom_range(90, 170);
            queue_market_bars(count, vol_bps, start_px);
            planned += count;
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/avc_pkg.sv
src/avc_bar_if.sv
src/avc_result_if.sv
src/avc_cfg_if.sv
src/avc_ram.sv
src/avc_front.sv
src/avc_queue.sv
src/avc_back.sv
src/atr_volatility_classifier_unit.sv
test/tb_atr_volatility_classifier_unit.sv
